// ===== hdl/csp_gen_pkg.sv =====
// Shared types and constants of the cell side pin site generator.
// No dependencies; imported by csp_gen_iter_unit, the top level and the testbench.
`default_nettype none

package csp_gen_pkg;

	// 0.01 in Q9.16, rounded down, and 1.0 in Q.16
	localparam logic [24:0] ASPECT_TOL = 25'd655;
	localparam logic [28:0] ONE_Q16    = 29'd65536;

	// register byte addresses
	localparam logic [2:0] ADDR_VERT_SPACING = 3'd0;
	localparam logic [2:0] ADDR_HORZ_SPACING = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [23:0] fixed_coord;
		logic [23:0] start_coord;
		logic [23:0] end_coord;
		logic [23:0] aspect_ratio;
		logic [23:0] aspect_lower;
		logic [23:0] aspect_upper;
		logic        write_sites;
	} csp_side_t;

	typedef struct packed {
		logic [6:0]  site_number;
		logic [24:0] site_x;
		logic [24:0] site_y;
		logic [23:0] site_span;
		logic [23:0] site_capacity;
		logic        vertical_site;
		logic [6:0]  total_sites;
		logic        no_site;
		logic        last;
	} csp_site_t;

	typedef enum logic [1:0] {
		OP_DIV,
		OP_SQRT,
		OP_MUL
	} csp_op_t;

	// command to the shared unit; operand a is left aligned in 64 bits
	typedef struct packed {
		logic        start;
		csp_op_t     op;
		logic [63:0] a;
		logic [28:0] b;
		logic [5:0]  n;
	} csp_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
		logic [31:0] rem;
	} csp_res_t;

endpackage

`default_nettype wire

// ===== hdl/csp_gen_iter_unit.sv =====
// Shared iterative unit: restoring divide, digit-by-digit square root and
// shift-add multiply, one step per cycle. Depends on csp_gen_pkg.
`default_nettype none

module csp_gen_iter_unit
	import csp_gen_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire csp_cmd_t cmd,
	output csp_res_t      res
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q, n_q;
	csp_op_t     op_q;
	logic [63:0] x_q, acc_q;
	logic [31:0] r_q;
	logic [28:0] d_q;

	// one shared compare and subtract
	logic [31:0] cmp_a, cmp_b, diff;
	logic        ge;

	always_comb begin
		case (op_q)
			OP_SQRT: begin
				cmp_a = {r_q[29:0], x_q[63:62]};
				cmp_b = {acc_q[29:0], 2'b01};
			end
			default: begin
				cmp_a = {r_q[30:0], x_q[63]};
				cmp_b = {3'b000, d_q};
			end
		endcase
		ge   = cmp_a >= cmp_b;
		diff = cmp_a - cmp_b;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !cmd.start && (cnt_q == n_q - 6'd1);
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == n_q - 6'd1) busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			n_q   <= cmd.n;
			d_q   <= cmd.b;
			x_q   <= cmd.a;
			r_q   <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					x_q <= {x_q[62:0], ge};
					r_q <= ge ? diff : cmp_a;
				end
				OP_SQRT: begin
					x_q   <= {x_q[61:0], 2'b00};
					acc_q <= {acc_q[62:0], ge};
					r_q   <= ge ? diff : cmp_a;
				end
				default: begin
					x_q   <= {x_q[62:0], 1'b0};
					acc_q <= {acc_q[62:0], 1'b0} + (x_q[63] ? {35'd0, d_q} : 64'd0);
				end
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.value = (op_q == OP_DIV) ? x_q : acc_q;
	assign res.rem   = r_q;

endmodule

`default_nettype wire

// ===== hdl/cell_side_pin_site_generator_unit.sv =====
// Top level of the cell side pin site generator: APB registers, sequencer,
// site stepping and output register. Depends on csp_gen_pkg, csp_gen_iter_unit.
//
// One side word runs a chain of operations through the shared iterative unit:
// 56-step ratio divide, 28-step root, 24-step multiply, 37-step pitch divide,
// a 37-step capacity divide when pins exceed MAX_SITES, and a 25-step spacing
// divide. The ratio divide and the root are skipped when the aspect bounds
// are within tolerance. After a setup state the site words are loaded, one
// site word per cycle while the receiver does not stall, up to MAX_SITES; a
// count word follows the pitch divide directly. sd_stall is high from
// acceptance until the last result word is loaded into the output register.
`default_nettype none

module cell_side_pin_site_generator_unit
	import csp_gen_pkg::*;
#(
	parameter int MAX_SITES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        sd_valid,
	output logic             sd_stall,
	input  wire csp_side_t   sd,
	output logic             site_valid,
	input  wire logic        site_stall,
	output csp_site_t        site
);

	localparam logic [36:0] MAX_P = 37'(MAX_SITES);
	localparam logic [6:0]  MAX_T = 7'(MAX_SITES);

	typedef enum logic [3:0] {
		S_IDLE, S_RATIO, S_ROOT, S_MUL, S_PITCH, S_CAP, S_STEP, S_PREP, S_EMIT, S_COUNT
	} state_t;

	state_t      state_q;
	csp_cmd_t    cmd_q;
	csp_res_t    res;
	logic [15:0] vts_q, hts_q;
	csp_side_t   side_q;
	logic [23:0] len_q;
	logic [36:0] p_q, capq_q;
	logic [6:0]  t_q, k_q, caprem_q;
	logic [7:0]  d_q, r_q, incr_q;
	logic [24:0] q_q, inc_q;
	logic        site_valid_q;
	csp_site_t   site_q;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'd0, hts_q} : {16'd0, vts_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vts_q <= 16'd1;
			hts_q <= 16'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) hts_q <= pwdata[15:0];
			else          vts_q <= pwdata[15:0];
		end
	end

	csp_gen_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_q),
		.res    (res)
	);

	// front end on the incoming word
	logic [24:0] s_in, e_in, len_diff;
	logic [23:0] len_in, num_in, den_in;
	logic        vert_in, tol_in;

	always_comb begin
		vert_in  = !sd.operation;
		s_in     = {sd.start_coord[23], sd.start_coord};
		e_in     = {sd.end_coord[23], sd.end_coord};
		len_diff = ($signed(e_in) > $signed(s_in)) ? e_in - s_in : s_in - e_in;
		len_in   = len_diff[23:0];
		tol_in   = ({1'b0, sd.aspect_lower} + ASPECT_TOL) > {1'b0, sd.aspect_upper};
		num_in   = vert_in ? sd.aspect_lower : sd.aspect_ratio;
		den_in   = vert_in ? sd.aspect_ratio : sd.aspect_upper;
		if (den_in == 24'd0) den_in = 24'd1;
	end

	// pin count from the rounded length
	logic [52:0] wsum;
	logic [36:0] p_n;
	logic [6:0]  t_n;
	logic [7:0]  d_n;
	logic [15:0] sp;

	always_comb begin
		wsum = res.value[52:0] + 53'd32767;
		p_n  = (res.value[36:0] != 37'd0) ? res.value[36:0] - 37'd1 : 37'd0;
		t_n  = (p_n < MAX_P) ? p_n[6:0] : MAX_T;
		d_n  = {t_q + 7'd1, 1'b0};
		sp   = side_q.operation ? hts_q : vts_q;
		if (sp == 16'd0) sp = 16'd1;
	end

	// next site position: add the spacing quotient, wrap the remainder once
	logic [8:0]  rsum;
	logic        wrap;
	logic [7:0]  r_n;
	logic [24:0] q_n;

	always_comb begin
		rsum = {1'b0, r_q} + {1'b0, incr_q};
		wrap = rsum >= {1'b0, d_q};
		r_n  = wrap ? 8'(rsum - {1'b0, d_q}) : rsum[7:0];
		q_n  = q_q + inc_q + {24'd0, wrap};
	end

	// site word fields
	logic [24:0] s_q25, fix25, along;
	logic [37:0] capsum;
	logic [23:0] cap;
	logic        dir;

	always_comb begin
		s_q25  = {side_q.start_coord[23], side_q.start_coord};
		fix25  = {side_q.fixed_coord[23], side_q.fixed_coord};
		dir    = $signed(side_q.end_coord) > $signed(side_q.start_coord);
		along  = dir ? s_q25 + q_q : s_q25 - q_q;
		capsum = {1'b0, capq_q} + {37'd0, (k_q <= caprem_q)};
		if (p_q > MAX_P) cap = (capsum > 38'hFFFFFF) ? 24'hFFFFFF : capsum[23:0];
		else             cap = 24'd1;
	end

	// count-only word
	csp_site_t count_word;

	always_comb begin
		count_word               = '0;
		count_word.vertical_site = !side_q.operation;
		count_word.total_sites   = t_q;
		count_word.no_site       = 1'b1;
		count_word.last          = 1'b1;
	end

	logic out_free;
	assign out_free = !site_valid_q || !site_stall;

	// unit launch and output load
	logic launch, load;

	always_comb begin
		unique case (state_q) inside
			S_IDLE:                         launch = sd_valid;
			S_RATIO, S_ROOT, S_MUL, S_CAP:  launch = res.done;
			S_PITCH: launch = res.done && side_q.write_sites && (t_n != 7'd0);
			default:                        launch = 1'b0;
		endcase
	end

	assign load = out_free && (state_q == S_EMIT || state_q == S_COUNT);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			site_valid_q <= 1'b0;
		end else begin
			if (load)                             site_valid_q <= 1'b1;
			else if (site_valid_q && !site_stall) site_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (sd_valid) state_q <= tol_in ? S_MUL : S_RATIO;
				end
				S_RATIO: if (res.done) state_q <= S_ROOT;
				S_ROOT:  if (res.done) state_q <= S_MUL;
				S_MUL:   if (res.done) state_q <= S_PITCH;
				S_PITCH: if (res.done) begin
					if (!side_q.write_sites || t_n == 7'd0) state_q <= S_COUNT;
					else state_q <= (p_n > MAX_P) ? S_CAP : S_STEP;
				end
				S_CAP:  if (res.done) state_q <= S_STEP;
				S_STEP: if (res.done) state_q <= S_PREP;
				S_PREP: state_q <= S_EMIT;
				S_EMIT: if (out_free && k_q == t_q) state_q <= S_IDLE;
				S_COUNT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands, intermediate values and output payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q.start <= 1'b0;
		end else begin
			cmd_q.start <= launch;
			case (state_q)
				S_IDLE: begin
					side_q <= sd;
					len_q  <= len_in;
					if (tol_in) begin
						cmd_q.op <= OP_MUL;
						cmd_q.a  <= {len_in, 40'd0};
						cmd_q.b  <= ONE_Q16;
						cmd_q.n  <= 6'd24;
					end else begin
						cmd_q.op <= OP_DIV;
						cmd_q.a  <= {num_in, 40'd0};
						cmd_q.b  <= {5'd0, den_in};
						cmd_q.n  <= 6'd56;
					end
				end
				S_RATIO: begin
					cmd_q.op <= OP_SQRT;
					cmd_q.a  <= {res.value[55:0], 8'd0};
					cmd_q.n  <= 6'd28;
				end
				S_ROOT: begin
					cmd_q.op <= OP_MUL;
					cmd_q.a  <= {len_q, 40'd0};
					cmd_q.b  <= res.value[28:0];
					cmd_q.n  <= 6'd24;
				end
				S_MUL: begin
					cmd_q.op <= OP_DIV;
					cmd_q.a  <= {wsum[52:16], 27'd0};
					cmd_q.b  <= {13'd0, sp};
					cmd_q.n  <= 6'd37;
				end
				S_PITCH: begin
					p_q      <= p_n;
					t_q      <= t_n;
					cmd_q.op <= OP_DIV;
					if (p_n > MAX_P) begin
						cmd_q.a <= {p_n, 27'd0};
						cmd_q.b <= {22'd0, MAX_T};
						cmd_q.n <= 6'd37;
					end else begin
						cmd_q.a <= {len_q, 40'd0};
						cmd_q.b <= {21'd0, t_n + 7'd1, 1'b0};
						cmd_q.n <= 6'd25;
					end
				end
				S_CAP: begin
					capq_q   <= res.value[36:0];
					caprem_q <= res.rem[6:0];
					cmd_q.a  <= {len_q, 40'd0};
					cmd_q.b  <= {21'd0, d_n};
					cmd_q.n  <= 6'd25;
				end
				S_STEP: begin
					inc_q  <= res.value[24:0];
					incr_q <= res.rem[7:0];
					d_q    <= d_n;
					q_q    <= '0;
					r_q    <= {1'b0, t_q} + 8'd1;
				end
				S_PREP: begin
					q_q <= q_n;
					r_q <= r_n;
					k_q <= 7'd1;
				end
				S_EMIT: if (out_free) begin
					site_q.site_number   <= k_q;
					site_q.site_x        <= side_q.operation ? along : fix25;
					site_q.site_y        <= side_q.operation ? fix25 : along;
					site_q.site_span     <= 24'(q_n - q_q);
					site_q.site_capacity <= cap;
					site_q.vertical_site <= !side_q.operation;
					site_q.total_sites   <= t_q;
					site_q.no_site       <= 1'b0;
					site_q.last          <= (k_q == t_q);
					q_q <= q_n;
					r_q <= r_n;
					k_q <= k_q + 7'd1;
				end
				S_COUNT: if (out_free) site_q <= count_word;
				default: ;
			endcase
		end
	end

	assign sd_stall   = (state_q != S_IDLE);
	assign site_valid = site_valid_q;
	assign site       = site_q;

	// a count word always closes its side
	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid && site.no_site |-> site.last)
		else $error("count word without last");

	// a site word carries an index within the side's total
	a_site_index: assert property (@(posedge clk) disable iff (!arst_n)
		site_valid && !site.no_site |->
			site.site_number != 7'd0 && site.site_number <= site.total_sites)
		else $error("site index out of range");

	// the shared unit is never launched from idle except on an accepted word
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.start && $past(state_q == S_IDLE) |-> $past(sd_valid))
		else $error("unit launched without an accepted word");

endmodule

`default_nettype wire

// ===== tb/sv/csp_site_checker.sv =====
// Checker for the cell side pin site generator: tracks the spacing registers,
// predicts the site words of each accepted side word and compares them.
// Depends on csp_gen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csp_site_checker
	import csp_gen_pkg::*;
#(
	parameter int MAX_SITES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        sd_valid,
	input  wire logic        sd_stall,
	input  wire csp_side_t   sd,
	input  wire logic        site_valid,
	input  wire logic        site_stall,
	input  wire csp_site_t   site,
	output int               mismatches,
	output int               pending
);

	localparam logic [24:0] TOL = 25'd655;

	logic [15:0] vert_spacing = 16'd1;
	logic [15:0] horz_spacing = 16'd1;
	csp_site_t   site_queue[$];

	initial mismatches = 0;
	assign pending = site_queue.size();

	// bitwise integer square root, floor
	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] site_offset(logic [63:0] k, logic [63:0] len,
			logic [63:0] t);
		return (2 * k * len + t + 1) / (2 * (t + 1));
	endfunction

	// expected site words of one side word
	function automatic void predict_sites(csp_side_t s);
		logic        vert;
		longint      fx, st, en, along;
		logic [63:0] len, num, den, f, w, sp, p, t, p0, p1, cap;
		csp_site_t   r;
		vert = !s.operation;
		fx = longint'($signed(s.fixed_coord));
		st = longint'($signed(s.start_coord));
		en = longint'($signed(s.end_coord));
		len = (en > st) ? en - st : st - en;
		if ({1'b0, s.aspect_lower} + TOL > {1'b0, s.aspect_upper}) begin
			f = 64'd65536;
		end else begin
			num = vert ? 64'(s.aspect_lower) : 64'(s.aspect_ratio);
			den = vert ? 64'(s.aspect_ratio) : 64'(s.aspect_upper);
			if (den == 0) den = 1;
			f = root_floor((num << 32) / den);
		end
		w = (len * f + 64'd32767) >> 16;
		sp = vert ? 64'(vert_spacing) : 64'(horz_spacing);
		if (sp == 0) sp = 1;
		p = w / sp;
		p = (p > 0) ? p - 1 : 0;
		t = (p < MAX_SITES) ? p : 64'(MAX_SITES);
		r = '0;
		r.vertical_site = vert;
		r.total_sites = t[6:0];
		if (!s.write_sites || t == 0) begin
			r.no_site = 1'b1;
			r.last = 1'b1;
			site_queue.push_back(r);
			return;
		end
		for (longint k = 1; k <= t; k++) begin
			p0 = site_offset(k, len, t);
			p1 = site_offset(k + 1, len, t);
			along = (en > st) ? st + longint'(p0) : st - longint'(p0);
			if (p > MAX_SITES) begin
				cap = p / MAX_SITES;
				if (k <= p % MAX_SITES) cap++;
			end else begin
				cap = 1;
			end
			if (cap > 64'hFFFFFF) cap = 64'hFFFFFF;
			r.site_number = k[6:0];
			r.site_x = vert ? fx[24:0] : along[24:0];
			r.site_y = vert ? along[24:0] : fx[24:0];
			r.site_span = p1[23:0] - p0[23:0];
			r.site_capacity = cap[23:0];
			r.last = (k == t);
			site_queue.push_back(r);
		end
	endfunction

	// register writes, accepted side words and site words
	always @(posedge clk) begin
		csp_site_t exp_site;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_VERT_SPACING) vert_spacing <= pwdata[15:0];
				else if (paddr == ADDR_HORZ_SPACING) horz_spacing <= pwdata[15:0];
			end
			if (sd_valid && !sd_stall) predict_sites(sd);
			if (site_valid && !site_stall) begin
				if (site_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected site word %p", site);
				end else begin
					exp_site = site_queue.pop_front();
					if (site.site_number !== exp_site.site_number
							|| site.site_x !== exp_site.site_x
							|| site.site_y !== exp_site.site_y
							|| site.site_span !== exp_site.site_span
							|| site.site_capacity !== exp_site.site_capacity
							|| site.vertical_site !== exp_site.vertical_site
							|| site.total_sites !== exp_site.total_sites
							|| site.no_site !== exp_site.no_site
							|| site.last !== exp_site.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("site mismatch: expected %p, got %p", exp_site, site);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_cell_side_pin_site_generator_unit.sv =====
// Testbench top of the cell side pin site generator: clock, reset, APB
// setup, side word stimulus and verdict. Depends on csp_gen_pkg, csp_site_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_cell_side_pin_site_generator_unit;
	import csp_gen_pkg::*;

	localparam int MAX_SITES = 32;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 90;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        sd_valid = 1'b0;
	logic        sd_stall;
	csp_side_t   sd = '0;
	logic        site_valid;
	logic        site_stall = 1'b0;
	csp_site_t   site;
	int          mismatches, pending;
	bit          calm = 1'b0;

	always #6 clk = ~clk;

	cell_side_pin_site_generator_unit #(.MAX_SITES(MAX_SITES)) u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.sd_valid, .sd_stall, .sd, .site_valid, .site_stall, .site
	);

	csp_site_checker #(.MAX_SITES(MAX_SITES)) u_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.sd_valid, .sd_stall, .sd, .site_valid, .site_stall, .site,
		.mismatches, .pending
	);

	// setup and access cycle of one register write
	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_spacing(logic [15:0] vsp, logic [15:0] hsp);
		write_reg(ADDR_VERT_SPACING, {16'h0, vsp});
		write_reg(ADDR_HORZ_SPACING, {16'h0, hsp});
	endtask

	// hold one side word until it is taken
	task automatic send_side(csp_side_t s);
		if (!calm && $urandom_range(0, 5) == 0) begin
			sd_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		sd_valid <= 1'b1;
		sd <= s;
		do @(posedge clk); while (sd_stall);
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic csp_side_t make_side(bit op, int fx, int st, int en, int asp,
			int lo, int up, bit wr);
		csp_side_t s;
		s.operation = op;
		s.fixed_coord = fx[23:0];
		s.start_coord = st[23:0];
		s.end_coord = en[23:0];
		s.aspect_ratio = asp[23:0];
		s.aspect_lower = lo[23:0];
		s.aspect_upper = up[23:0];
		s.write_sites = wr;
		return s;
	endfunction

	// mostly plausible sides with ordered bounds, some raw noise
	function automatic csp_side_t random_side();
		csp_side_t s;
		logic [23:0] len, a, b, c;
		s = csp_side_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(0, 4) != 0) begin
			len = 24'($urandom & ((32'd1 << $urandom_range(0, 23)) - 32'd1));
			s.end_coord = $urandom_range(0, 1) ? s.start_coord + len : s.start_coord - len;
			a = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
			b = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
			c = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 8));
			s.aspect_lower = (a < b) ? a : b;
			s.aspect_upper = (a < b) ? b : a;
			s.aspect_ratio = $urandom_range(0, 1) ? c : s.aspect_lower + (c >> 2);
			s.write_sites = ($urandom_range(0, 5) != 0);
		end
		return s;
	endfunction

	// receiver stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 6) == 0) begin
				site_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				site_stall <= 1'b0;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("tb_cell_side_pin_site_generator_unit failed");
		$finish;
	end

	initial begin
		csp_side_t dir_sides[$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		set_spacing(16'd1, 16'd1);

		// directed: extremes, both sides, count only, tolerance edge, zero aspect
		dir_sides.push_back(make_side(0, 100, 0, 40, 65536, 0, 16777215, 1));
		dir_sides.push_back(make_side(1, -100, 40, 0, 65536, 0, 16777215, 1));
		dir_sides.push_back(make_side(0, 8388607, -8388608, 8388607, 1, 16777215,
			16777215, 1));
		dir_sides.push_back(make_side(0, -8388608, 8388607, -8388608, 1, 16776560,
			16777215, 1));
		dir_sides.push_back(make_side(1, 8388607, -8388608, 8388607, 16777215, 0, 1, 1));
		dir_sides.push_back(make_side(1, 0, 5, 5, 65536, 0, 65536, 1));
		dir_sides.push_back(make_side(0, 7, 10, 10, 65536, 0, 65536, 1));
		dir_sides.push_back(make_side(0, 3, 0, 50, 65536, 0, 65536, 0));
		dir_sides.push_back(make_side(1, 3, 0, 50, 65536, 0, 65536, 0));
		dir_sides.push_back(make_side(0, 1, 0, 1, 65536, 0, 65536, 1));
		dir_sides.push_back(make_side(0, 1, 0, 2, 65536, 0, 65536, 1));
		dir_sides.push_back(make_side(0, 1, 0, 3, 65536, 0, 65536, 1));
		dir_sides.push_back(make_side(0, 0, 0, 1000, 0, 65536, 131072, 1));
		dir_sides.push_back(make_side(1, 0, 0, 1000, 0, 65536, 0, 1));
		dir_sides.push_back(make_side(1, 0, 0, 1000, 65536, 65536, 66190, 1));
		dir_sides.push_back(make_side(1, 0, 0, 1000, 65536, 65536, 66191, 1));
		dir_sides.push_back(make_side(0, 0, 0, 1000, 65536, 65536, 66192, 1));
		dir_sides.push_back(make_side(0, 0, 0, 34, 65536, 0, 0, 1));
		dir_sides.push_back(make_side(1, 0, 0, 33, 65536, 0, 0, 1));
		dir_sides.push_back(make_side(0, 0, 100, -200, 30000, 20000, 90000, 1));
		foreach (dir_sides[i]) send_side(dir_sides[i]);
		sd_valid <= 1'b0;
		drain();

		// random phases, each with its own spacing
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_spacing(16'd65535, 16'd65535);
				1: set_spacing(16'd0, 16'd3);
				2: set_spacing(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
				3: set_spacing(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 300)));
				default: set_spacing(16'($urandom_range(1, 20)), 16'd1);
			endcase
			calm = (ph == PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) send_side(random_side());
			sd_valid <= 1'b0;
			drain();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_cell_side_pin_site_generator_unit passed");
		end else begin
			$display("tb_cell_side_pin_site_generator_unit failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/csp_gen_pkg.sv
hdl/csp_gen_iter_unit.sv
hdl/cell_side_pin_site_generator_unit.sv
tb/sv/csp_site_checker.sv
tb/sv/tb_cell_side_pin_site_generator_unit.sv
